FILE: hdl/four_neighbor_autotile_classifier_unit_macros.svh
// Assertion macros used by the autotile classifier top level.
`ifndef FOUR_NEIGHBOR_AUTOTILE_CLASSIFIER_UNIT_MACROS_SVH
`define FOUR_NEIGHBOR_AUTOTILE_CLASSIFIER_UNIT_MACROS_SVH

// Same-cycle implication, checked out of reset.
`define FNAC_ASSERT_IMP(name, clk, rstn, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, checked out of reset.
`define FNAC_ASSERT_NXT(name, clk, rstn, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) else $error(msg);

`endif

FILE: hdl/fnac_pkg.sv
// Shared types, constants and the rule lookup of the autotile classifier.
package fnac_pkg;

  localparam int MAX_WIDTH = 32;
  localparam int MAX_ROWS  = 1024;
  localparam int COL_W     = $clog2(MAX_WIDTH);
  localparam int ROW_W     = $clog2(MAX_ROWS);
  localparam int TILE_W    = 8;
  localparam int TEX_W     = 8;
  localparam int CFG_IDX_W = 2;
  localparam int CFG_DAT_W = 64;
  localparam int WCFG_W    = 6;
  localparam int HCFG_W    = 11;

  // Configuration register indexes.
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_MAP_WIDTH  = 2'd0,
    REG_MAP_HEIGHT = 2'd1,
    REG_RULES_LOW  = 2'd2,
    REG_RULES_HIGH = 2'd3
  } cfg_reg_e;

  // Controller states.
  typedef enum logic {
    ST_ACCEPT = 1'b0,
    ST_FLUSH  = 1'b1
  } ctrl_state_e;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic accept;      // input transfer this cycle
    logic flush;       // controller is sweeping the last row
    logic flush_step;  // one flush result is produced this cycle
    logic emit;        // load the output register
    logic restart;     // frame geometry was rewritten
  } ctrl_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic row_nonzero;
    logic col_last;
    logic row_last;
  } dp_status_t;

  // Pick the texture for a tile from its neighbor mask; empty tiles give 0.
  function automatic logic [TEX_W-1:0] classify(
    input logic                     self_occ,
    input logic [3:0]               mask,
    input logic [2*CFG_DAT_W-1:0]   rules
  );
    logic [TEX_W-1:0] tex;
    tex = rules[{mask, 3'b000} +: TEX_W];
    return self_occ ? tex : '0;
  endfunction

endpackage

FILE: hdl/fnac_ctrl.sv
// Controller state machine: input acceptance, row flush sequencing, output valid.
module fnac_ctrl (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  output logic                          in_stall_o,
  output logic                          out_valid_o,
  input  logic                          out_stall_i,
  input  logic                          cfg_valid_i,
  input  logic [fnac_pkg::CFG_IDX_W-1:0] cfg_index_i,
  input  fnac_pkg::dp_status_t          status_i,
  output fnac_pkg::ctrl_cmd_t           cmd_o
);

  fnac_pkg::ctrl_state_e state_q, state_d;
  logic                  out_valid_q, out_valid_d;
  logic                  out_free;
  fnac_pkg::cfg_reg_e    cfg_reg;

  assign cfg_reg  = fnac_pkg::cfg_reg_e'(cfg_index_i);
  // The output register can take a new result if empty or being drained.
  assign out_free = !out_valid_q || !out_stall_i;

  // State register and output valid flag.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= fnac_pkg::ST_ACCEPT;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Next state and commands.
  always_comb begin
    state_d    = state_q;
    cmd_o      = '0;
    in_stall_o = 1'b1;
    unique case (state_q)
      fnac_pkg::ST_ACCEPT: begin
        in_stall_o   = !out_free;
        cmd_o.accept = in_valid_i && out_free;
        cmd_o.emit   = cmd_o.accept && status_i.row_nonzero;
        if (cmd_o.accept && status_i.col_last && status_i.row_last) begin
          state_d = fnac_pkg::ST_FLUSH;
        end
      end
      fnac_pkg::ST_FLUSH: begin
        cmd_o.flush      = 1'b1;
        cmd_o.flush_step = out_free;
        cmd_o.emit       = out_free;
        if (out_free && status_i.col_last) begin
          state_d = fnac_pkg::ST_ACCEPT;
        end
      end
      default: state_d = fnac_pkg::ST_ACCEPT;
    endcase

    // A geometry write restarts the frame.
    cmd_o.restart = cfg_valid_i &&
                    (cfg_reg == fnac_pkg::REG_MAP_WIDTH ||
                     cfg_reg == fnac_pkg::REG_MAP_HEIGHT);
    if (cmd_o.restart) begin
      state_d = fnac_pkg::ST_ACCEPT;
    end

    // Output valid holds until the result transfers.
    if (cmd_o.emit) begin
      out_valid_d = 1'b1;
    end else begin
      out_valid_d = out_valid_q && out_stall_i;
    end
  end

  assign out_valid_o = out_valid_q;

endmodule

FILE: hdl/fnac_datapath.sv
// Datapath: configuration registers, row stores, neighbor window, counters and result register.
module fnac_datapath (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic [fnac_pkg::TILE_W-1:0]    tile_value_i,
  input  logic                           cfg_valid_i,
  input  logic [fnac_pkg::CFG_IDX_W-1:0] cfg_index_i,
  input  logic [fnac_pkg::CFG_DAT_W-1:0] cfg_data_i,
  input  fnac_pkg::ctrl_cmd_t            cmd_i,
  output fnac_pkg::dp_status_t           status_o,
  output logic [fnac_pkg::TEX_W-1:0]     texture_index_o,
  output logic [fnac_pkg::COL_W-1:0]     column_o,
  output logic [fnac_pkg::ROW_W-1:0]     row_o,
  output logic                           frame_done_o
);

  // Configuration, stored as last column and last row.
  logic [fnac_pkg::COL_W-1:0]     w_last_q;
  logic [fnac_pkg::ROW_W-1:0]     h_last_q;
  logic [fnac_pkg::CFG_DAT_W-1:0] rules_low_q, rules_high_q;
  logic [fnac_pkg::WCFG_W-1:0]    w_val;
  logic [fnac_pkg::HCFG_W-1:0]    h_val;
  fnac_pkg::cfg_reg_e             cfg_reg;

  // Frame position and occupancy stores.
  logic [fnac_pkg::COL_W-1:0] col_q, col_d, col_inc;
  logic [fnac_pkg::ROW_W-1:0] row_q, row_d;
  logic                       bank_q, bank_d;
  logic                       row_a_q [fnac_pkg::MAX_WIDTH];
  logic                       row_b_q [fnac_pkg::MAX_WIDTH];

  // Neighbor window over the row being classified.
  logic win_left_q, win_left_d, win_self_q, win_self_d;
  logic first_q;

  logic [fnac_pkg::COL_W-1:0] cur_addr, prv_addr, a_addr, b_addr;
  logic                       a_rd, b_rd, cur_rd, prv_rd;
  logic                       tile_occ, col_last, row_last, row_ge2;
  logic                       nb_below, nb_above, nb_right;
  logic [fnac_pkg::TEX_W-1:0] tex;

  assign cfg_reg  = fnac_pkg::cfg_reg_e'(cfg_index_i);
  assign w_val    = cfg_data_i[fnac_pkg::WCFG_W-1:0];
  assign h_val    = cfg_data_i[fnac_pkg::HCFG_W-1:0];
  assign tile_occ = (tile_value_i != '0);
  assign col_inc  = col_q + 1'b1;
  assign col_last = (col_q == w_last_q);
  assign row_last = (row_q == h_last_q);
  assign row_ge2  = (row_q[fnac_pkg::ROW_W-1:1] != '0);

  assign status_o.row_nonzero = (row_q != '0);
  assign status_o.col_last    = col_last;
  assign status_o.row_last    = row_last;

  // Configuration registers, saturated on write.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      w_last_q     <= '0;
      h_last_q     <= '0;
      rules_low_q  <= '0;
      rules_high_q <= '0;
    end else if (cfg_valid_i) begin
      unique case (cfg_reg)
        fnac_pkg::REG_MAP_WIDTH: begin
          if (w_val == '0) begin
            w_last_q <= '0;
          end else if (w_val > fnac_pkg::WCFG_W'(fnac_pkg::MAX_WIDTH)) begin
            w_last_q <= fnac_pkg::COL_W'(fnac_pkg::MAX_WIDTH - 1);
          end else begin
            w_last_q <= fnac_pkg::COL_W'(w_val - 1'b1);
          end
        end
        fnac_pkg::REG_MAP_HEIGHT: begin
          if (h_val == '0) begin
            h_last_q <= '0;
          end else if (h_val > fnac_pkg::HCFG_W'(fnac_pkg::MAX_ROWS)) begin
            h_last_q <= fnac_pkg::ROW_W'(fnac_pkg::MAX_ROWS - 1);
          end else begin
            h_last_q <= fnac_pkg::ROW_W'(h_val - 1'b1);
          end
        end
        fnac_pkg::REG_RULES_LOW:  rules_low_q  <= cfg_data_i;
        fnac_pkg::REG_RULES_HIGH: rules_high_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // Read ports: the incoming row store and the row above, one address each.
  always_comb begin
    cur_addr = cmd_i.flush ? col_inc : col_q;
    prv_addr = cmd_i.flush ? col_q : col_inc;
    a_addr   = bank_q ? prv_addr : cur_addr;
    b_addr   = bank_q ? cur_addr : prv_addr;
  end

  assign a_rd   = row_a_q[a_addr];
  assign b_rd   = row_b_q[b_addr];
  assign cur_rd = bank_q ? b_rd : a_rd;
  assign prv_rd = bank_q ? a_rd : b_rd;

  // Neighbor bits for the tile being classified.
  always_comb begin
    if (cmd_i.flush) begin
      nb_below = 1'b0;
      nb_above = status_o.row_nonzero && prv_rd;
      nb_right = !col_last && cur_rd;
    end else begin
      nb_below = tile_occ;
      nb_above = row_ge2 && cur_rd;
      nb_right = !col_last && prv_rd;
    end
  end

  assign tex = fnac_pkg::classify(win_self_q, {nb_below, nb_above, nb_right, win_left_q},
                                  {rules_high_q, rules_low_q});

  // Counter, bank and window updates.
  always_comb begin
    col_d      = col_q;
    row_d      = row_q;
    bank_d     = bank_q;
    win_left_d = win_left_q;
    win_self_d = win_self_q;
    if (cmd_i.restart) begin
      col_d  = '0;
      row_d  = '0;
      bank_d = 1'b0;
    end else if (cmd_i.accept) begin
      if (col_last) begin
        // Next pass starts at column zero of the row just completed.
        col_d      = '0;
        win_left_d = 1'b0;
        win_self_d = (col_q == '0) ? tile_occ : first_q;
        if (!row_last) begin
          row_d  = row_q + 1'b1;
          bank_d = !bank_q;
        end
      end else begin
        col_d      = col_inc;
        win_left_d = win_self_q;
        win_self_d = prv_rd;
      end
    end else if (cmd_i.flush_step) begin
      if (col_last) begin
        col_d  = '0;
        row_d  = '0;
        bank_d = 1'b0;
      end else begin
        col_d      = col_inc;
        win_left_d = win_self_q;
        win_self_d = cur_rd;
      end
    end
  end

  // Position registers and occupancy stores.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q  <= '0;
      row_q  <= '0;
      bank_q <= 1'b0;
      for (int i = 0; i < fnac_pkg::MAX_WIDTH; i++) begin
        row_a_q[i] <= 1'b0;
        row_b_q[i] <= 1'b0;
      end
    end else begin
      col_q  <= col_d;
      row_q  <= row_d;
      bank_q <= bank_d;
      if (cmd_i.accept) begin
        if (bank_q) begin
          row_b_q[col_q] <= tile_occ;
        end else begin
          row_a_q[col_q] <= tile_occ;
        end
      end
    end
  end

  // Window, first-column bit and result payload.
  always_ff @(posedge clk_i) begin
    win_left_q <= win_left_d;
    win_self_q <= win_self_d;
    if (cmd_i.accept && col_q == '0) begin
      first_q <= tile_occ;
    end
    if (cmd_i.emit) begin
      texture_index_o <= tex;
      column_o        <= col_q;
      row_o           <= cmd_i.flush ? row_q : row_q - 1'b1;
      frame_done_o    <= cmd_i.flush && col_last;
    end
  end

endmodule

FILE: hdl/four_neighbor_autotile_classifier_unit.sv
// Four-neighbor autotile classifier: streams a tile map in raster order and
// returns one texture index per tile, chosen by which of its four neighbors
// are occupied. One tile is taken per clock while the result side is not
// stalled. A tile's result leaves once the tile below it has arrived, so the
// first row gives no results. The last tile of a frame is followed by a sweep
// of the final row, one result per cycle while the result side is not stalled,
// during which no tile is taken. Row occupancy sits in two flip-flop banks
// cleared by reset, so no clearing pass is needed. Writing map_width or
// map_height restarts the frame; configuration is written only while idle,
// a rule for the user that the block does not enforce. The write channel is
// always ready.
module four_neighbor_autotile_classifier_unit (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           in_valid_i,
  output logic                           in_stall_o,
  input  logic [fnac_pkg::TILE_W-1:0]    tile_value_i,
  output logic                           out_valid_o,
  input  logic                           out_stall_i,
  output logic [fnac_pkg::TEX_W-1:0]     texture_index_o,
  output logic [fnac_pkg::COL_W-1:0]     column_o,
  output logic [fnac_pkg::ROW_W-1:0]     row_o,
  output logic                           frame_done_o,
  input  logic                           cfg_valid_i,
  output logic                           cfg_ready_o,
  input  logic [fnac_pkg::CFG_IDX_W-1:0] cfg_index_i,
  input  logic [fnac_pkg::CFG_DAT_W-1:0] cfg_data_i
);

  `include "four_neighbor_autotile_classifier_unit_macros.svh"

  fnac_pkg::ctrl_cmd_t  cmd;
  fnac_pkg::dp_status_t status;

  assign cfg_ready_o = 1'b1;

  // Sequencing.
  fnac_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .cfg_valid_i (cfg_valid_i),
    .cfg_index_i (cfg_index_i),
    .status_i    (status),
    .cmd_o       (cmd)
  );

  // Classification and storage.
  fnac_datapath u_datapath (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .tile_value_i    (tile_value_i),
    .cfg_valid_i     (cfg_valid_i),
    .cfg_index_i     (cfg_index_i),
    .cfg_data_i      (cfg_data_i),
    .cmd_i           (cmd),
    .status_o        (status),
    .texture_index_o (texture_index_o),
    .column_o        (column_o),
    .row_o           (row_o),
    .frame_done_o    (frame_done_o)
  );

  // No tile is taken while the last row is being swept out.
  `FNAC_ASSERT_IMP(a_no_input_in_flush, clk_i, rst_ni, cmd.flush, in_stall_o, "tile taken during flush")
  // A waiting result is never overwritten.
  `FNAC_ASSERT_IMP(a_no_overwrite, clk_i, rst_ni, out_valid_o && out_stall_i, !cmd.emit, "result overwritten")
  // A tile below the first row always yields a result on the next cycle.
  `FNAC_ASSERT_NXT(a_accept_emits, clk_i, rst_ni, cmd.accept && status.row_nonzero, out_valid_o, "result missing")

endmodule

FILE: tb/tb.sv
// Self-checking testbench for the four-neighbor autotile classifier unit.
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int WATCHDOG_CYCLES = 2000;
  localparam int SETTLE_CYCLES   = 8;
  localparam int HOLD_CYCLES     = 200;
  localparam int RANDOM_TILES    = 44;
  localparam int TALL_TILES      = 12;
  localparam int MAX_REPORTS     = 10;

  // One texel as it leaves the block.
  typedef struct packed {
    logic [fnac_pkg::TEX_W-1:0] texture;
    logic [fnac_pkg::COL_W-1:0] column;
    logic [fnac_pkg::ROW_W-1:0] row;
    logic                       frame_done;
  } texel_t;

  logic                           clk        = 1'b0;
  logic                           rst_n      = 1'b0;
  logic                           in_valid   = 1'b0;
  logic [fnac_pkg::TILE_W-1:0]    tile_value = '0;
  logic                           out_stall  = 1'b0;
  logic                           cfg_valid  = 1'b0;
  fnac_pkg::cfg_reg_e             cfg_index  = fnac_pkg::REG_MAP_WIDTH;
  logic [fnac_pkg::CFG_DAT_W-1:0] cfg_data   = '0;

  logic                           in_stall;
  logic                           out_valid;
  logic [fnac_pkg::TEX_W-1:0]     texture_index;
  logic [fnac_pkg::COL_W-1:0]     column;
  logic [fnac_pkg::ROW_W-1:0]     row;
  logic                           frame_done;
  logic                           cfg_ready;

  // Shadow copy of the block: registers, occupancy banks and raster position.
  logic [fnac_pkg::WCFG_W-1:0]    width_reg  = 6'd1;
  logic [fnac_pkg::HCFG_W-1:0]    height_reg = 11'd1;
  logic [fnac_pkg::CFG_DAT_W-1:0] rules_lo   = '0;
  logic [fnac_pkg::CFG_DAT_W-1:0] rules_hi   = '0;
  logic [fnac_pkg::MAX_WIDTH-1:0] occ [2]    = '{'0, '0};
  int                             col_pos    = 0;
  int                             row_pos    = 0;
  logic                           bank       = 1'b0;

  logic [fnac_pkg::TILE_W-1:0]    tile_q [$];
  texel_t                         texel_q [$];
  logic                           tile_taken     = 1'b0;
  int                             send_idle_pct  = 0;
  int                             recv_stall_pct = 0;
  int                             long_hold      = 0;
  int                             mismatch_count = 0;
  int                             quiet_cycles   = 0;

  // Directed 4x4 map with mixed values to hit edges, corners and holes.
  logic [fnac_pkg::TILE_W-1:0] grid_4x4 [16] = '{
    8'hFF, 8'h00, 8'h01, 8'h80,
    8'h7F, 8'h00, 8'h00, 8'hFE,
    8'h00, 8'h55, 8'hAA, 8'h01,
    8'h80, 8'h00, 8'hFF, 8'h00
  };

  four_neighbor_autotile_classifier_unit dut (
    .clk_i           (clk),
    .rst_ni          (rst_n),
    .in_valid_i      (in_valid),
    .in_stall_o      (in_stall),
    .tile_value_i    (tile_value),
    .out_valid_o     (out_valid),
    .out_stall_i     (out_stall),
    .texture_index_o (texture_index),
    .column_o        (column),
    .row_o           (row),
    .frame_done_o    (frame_done),
    .cfg_valid_i     (cfg_valid),
    .cfg_ready_o     (cfg_ready),
    .cfg_index_i     (cfg_index),
    .cfg_data_i      (cfg_data)
  );

  // Clock with a 10 ns period.
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Effective map width: zero acts as one, large values clamp to the row buffer.
  function automatic int span_cols(input logic [fnac_pkg::WCFG_W-1:0] w);
    if (w == '0) return 1;
    if (w > fnac_pkg::MAX_WIDTH) return fnac_pkg::MAX_WIDTH;
    return int'(w);
  endfunction

  // Effective map height: zero acts as one, large values clamp to the row limit.
  function automatic int span_rows(input logic [fnac_pkg::HCFG_W-1:0] h);
    if (h == '0) return 1;
    if (h > fnac_pkg::MAX_ROWS) return fnac_pkg::MAX_ROWS;
    return int'(h);
  endfunction

  // Texture lookup by neighbor mask; an empty tile always maps to zero.
  function automatic logic [fnac_pkg::TEX_W-1:0] texture_for(input logic self_occ,
                                                             input logic [3:0] mask);
    logic [fnac_pkg::TEX_W-1:0] tex;
    if (mask[3]) tex = rules_hi[{mask[2:0], 3'b000} +: fnac_pkg::TEX_W];
    else tex = rules_lo[{mask[2:0], 3'b000} +: fnac_pkg::TEX_W];
    return self_occ ? tex : '0;
  endfunction

  function automatic logic [fnac_pkg::TILE_W-1:0] random_tile(input int density);
    if ($urandom_range(99) < density) return fnac_pkg::TILE_W'($urandom_range(1, 255));
    return '0;
  endfunction

  // Append one tile to the pending queue.
  task automatic queue_tile(input logic [fnac_pkg::TILE_W-1:0] tile);
    tile_q = {tile_q, tile};
  endtask

  task automatic restart_frame();
    col_pos = 0;
    row_pos = 0;
    bank = 1'b0;
  endtask

  task automatic push_texel(input logic [fnac_pkg::TEX_W-1:0] tex, input int col, input int r,
                            input logic done);
    texel_t t;
    t.texture = tex;
    t.column = fnac_pkg::COL_W'(col);
    t.row = fnac_pkg::ROW_W'(r);
    t.frame_done = done;
    texel_q = {texel_q, t};
  endtask

  // Work out the texels that one accepted tile releases.
  task automatic predict_tile(input logic [fnac_pkg::TILE_W-1:0] tile);
    int w, h, c, r, x;
    logic cur, prv, here, up, lf, rt;
    w = span_cols(width_reg);
    h = span_rows(height_reg);
    c = col_pos;
    r = row_pos;
    cur = bank;
    prv = !bank;
    here = (tile != '0);
    if (c >= w || r >= h) begin
      restart_frame();
      c = 0;
      r = 0;
      cur = 1'b0;
      prv = 1'b1;
    end
    // The tile above this one is now complete: its lower neighbor just arrived.
    if (r > 0) begin
      up = (r >= 2) ? occ[cur][c] : 1'b0;
      lf = (c > 0) ? occ[prv][c-1] : 1'b0;
      rt = (c + 1 < w) ? occ[prv][c+1] : 1'b0;
      push_texel(texture_for(occ[prv][c], {here, up, rt, lf}), c, r - 1, 1'b0);
    end
    occ[cur][c] = here;
    if (c == w - 1 && r == h - 1) begin
      // Last tile of the frame: sweep the final row left to right.
      for (x = 0; x < w; x++) begin
        up = (r > 0) ? occ[prv][x] : 1'b0;
        lf = (x > 0) ? occ[cur][x-1] : 1'b0;
        rt = (x + 1 < w) ? occ[cur][x+1] : 1'b0;
        push_texel(texture_for(occ[cur][x], {1'b0, up, rt, lf}), x, r, x == w - 1);
      end
      restart_frame();
    end else if (c == w - 1) begin
      col_pos = 0;
      row_pos = r + 1;
      bank = !bank;
    end else begin
      col_pos = c + 1;
    end
  endtask

  task automatic apply_reg(input fnac_pkg::cfg_reg_e idx,
                           input logic [fnac_pkg::CFG_DAT_W-1:0] data);
    case (idx)
      fnac_pkg::REG_MAP_WIDTH: begin
        width_reg = data[fnac_pkg::WCFG_W-1:0];
        restart_frame();
      end
      fnac_pkg::REG_MAP_HEIGHT: begin
        height_reg = data[fnac_pkg::HCFG_W-1:0];
        restart_frame();
      end
      fnac_pkg::REG_RULES_LOW: rules_lo = data;
      fnac_pkg::REG_RULES_HIGH: rules_hi = data;
      default: ;
    endcase
  endtask

  task automatic check_texel();
    texel_t want;
    if (texel_q.size() == 0) begin
      mismatch_count++;
      if (mismatch_count <= MAX_REPORTS)
        $display("unexpected texel: tex %0h col %0d row %0d done %0b",
                 texture_index, column, row, frame_done);
    end else begin
      want = texel_q.pop_front();
      if (want.texture !== texture_index || want.column !== column ||
          want.row !== row || want.frame_done !== frame_done) begin
        mismatch_count++;
        if (mismatch_count <= MAX_REPORTS)
          $display({"texel mismatch: expected tex %0h col %0d row %0d done %0b, ",
                    "got tex %0h col %0d row %0d done %0b"},
                   want.texture, want.column, want.row, want.frame_done,
                   texture_index, column, row, frame_done);
      end
    end
  endtask

  // Tile driver: offers the next queued tile once the current one is taken.
  always @(negedge clk) begin
    if (rst_n && (!in_valid || tile_taken)) begin
      if (tile_q.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
        in_valid <= 1'b1;
        tile_value <= tile_q.pop_front();
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // Result side stall: random back-pressure, or a long hold-off when requested.
  always @(negedge clk) begin
    if (long_hold > 0) begin
      out_stall <= 1'b1;
      long_hold = long_hold - 1;
    end else begin
      out_stall <= ($urandom_range(99) < recv_stall_pct);
    end
  end

  // Monitor: tracks register writes and tile transfers, checks every texel.
  always @(posedge clk) begin
    if (rst_n) begin
      tile_taken = in_valid && !in_stall;
      if (cfg_valid && cfg_ready) apply_reg(cfg_index, cfg_data);
      if (tile_taken) predict_tile(tile_value);
      if (out_valid && !out_stall) check_texel();
    end
  end

  // Watchdog on cycles without any transfer.
  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall) || (cfg_valid && cfg_ready))
      quiet_cycles = 0;
    else
      quiet_cycles = quiet_cycles + 1;
    if (quiet_cycles >= WATCHDOG_CYCLES) begin
      $display("watchdog expired after %0d quiet cycles", quiet_cycles);
      $display("Regression FAIL");
      $finish;
    end
  end

  task automatic write_reg(input fnac_pkg::cfg_reg_e idx,
                           input logic [fnac_pkg::CFG_DAT_W-1:0] data);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    do @(posedge clk); while (!cfg_ready);
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  // Wait until every queued tile is taken and every texel has come out.
  task automatic drain();
    while (tile_q.size() != 0 || in_valid) @(posedge clk);
    while (texel_q.size() != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  function automatic logic [fnac_pkg::CFG_DAT_W-1:0] random_rules();
    int sel;
    sel = $urandom_range(4);
    if (sel == 0) return '1;
    if (sel == 1) return '0;
    return {$urandom, $urandom};
  endfunction

  // One random layout: new geometry, maybe new rules, whole frames and
  // sometimes a trailing partial frame that the next geometry write cuts off.
  // No more than budget tiles are queued.
  task automatic random_layout(input int budget, output int count);
    logic [fnac_pkg::WCFG_W-1:0] w;
    logic [fnac_pkg::HCFG_W-1:0] h;
    int ew, eh, sel, density, extra, i;
    sel = $urandom_range(9);
    if (sel == 0) w = '0;
    else if (sel == 1) w = fnac_pkg::WCFG_W'($urandom_range(33, 63));
    else if (sel == 2) w = fnac_pkg::WCFG_W'(fnac_pkg::MAX_WIDTH);
    else w = fnac_pkg::WCFG_W'($urandom_range(1, 8));
    sel = $urandom_range(9);
    if (sel == 0) h = '0;
    else if (sel == 1) h = 11'd1;
    else h = fnac_pkg::HCFG_W'($urandom_range(2, 5));
    ew = span_cols(w);
    eh = span_rows(h);
    if (ew > 8 && eh > 3) begin
      h = 11'd3;
      eh = 3;
    end
    if ($urandom_range(1)) write_reg(fnac_pkg::REG_RULES_LOW, random_rules());
    if ($urandom_range(1)) write_reg(fnac_pkg::REG_RULES_HIGH, random_rules());
    if ($urandom_range(1)) begin
      write_reg(fnac_pkg::REG_MAP_WIDTH, fnac_pkg::CFG_DAT_W'(w));
      write_reg(fnac_pkg::REG_MAP_HEIGHT, fnac_pkg::CFG_DAT_W'(h));
    end else begin
      write_reg(fnac_pkg::REG_MAP_HEIGHT, fnac_pkg::CFG_DAT_W'(h));
      write_reg(fnac_pkg::REG_MAP_WIDTH, fnac_pkg::CFG_DAT_W'(w));
    end
    extra = 0;
    if (ew * eh > 1 && $urandom_range(4) == 0) extra = $urandom_range(1, ew * eh - 1);
    count = $urandom_range(1, 2) * ew * eh + extra;
    if (count > budget) count = budget;
    sel = $urandom_range(3);
    density = (sel == 0) ? 20 : (sel == 1) ? 50 : (sel == 2) ? 80 : 100;
    for (i = 0; i < count; i++) queue_tile(random_tile(density));
    drain();
  endtask

  initial begin
    int pass, fed, n, i;
    repeat (10) @(negedge clk);
    rst_n <= 1'b1;

    // Directed part under the first idling mix.
    send_idle_pct = 6;
    recv_stall_pct = 48;

    // Reset geometry is a 1x1 map with all rules zero.
    queue_tile(8'hFF);
    queue_tile(8'h00);
    drain();

    // Distinct texture per mask on a 4x4 map.
    write_reg(fnac_pkg::REG_RULES_LOW, 64'h1716151413121110);
    write_reg(fnac_pkg::REG_RULES_HIGH, 64'h1F1E1D1C1B1A1918);
    write_reg(fnac_pkg::REG_MAP_WIDTH, 64'd4);
    write_reg(fnac_pkg::REG_MAP_HEIGHT, 64'd4);
    for (i = 0; i < 16; i++) queue_tile(grid_4x4[i]);
    drain();

    // Zero width and zero height behave as a 1x1 map.
    write_reg(fnac_pkg::REG_RULES_LOW, '1);
    write_reg(fnac_pkg::REG_MAP_WIDTH, 64'd0);
    write_reg(fnac_pkg::REG_MAP_HEIGHT, 64'd0);
    queue_tile(8'h7F);
    drain();

    // Single-row frame: everything comes from the final sweep.
    write_reg(fnac_pkg::REG_RULES_HIGH, '1);
    write_reg(fnac_pkg::REG_MAP_WIDTH, 64'd5);
    write_reg(fnac_pkg::REG_MAP_HEIGHT, 64'd1);
    queue_tile(8'h01);
    queue_tile(8'h00);
    queue_tile(8'hFF);
    queue_tile(8'hFE);
    queue_tile(8'h02);
    drain();

    // Random part in three idling mixes.
    for (pass = 0; pass < 3; pass++) begin
      if (pass == 1) begin
        send_idle_pct = 48;
        recv_stall_pct = 6;
      end else if (pass == 2) begin
        send_idle_pct = 0;
        recv_stall_pct = 0;
        // Long hold-off on the result side while tiles keep coming.
        write_reg(fnac_pkg::REG_MAP_WIDTH, 64'd63);
        write_reg(fnac_pkg::REG_MAP_HEIGHT, 64'd2);
        for (i = 0; i < fnac_pkg::MAX_WIDTH * 2; i++) queue_tile(random_tile(60));
        @(posedge clk);
        long_hold = HOLD_CYCLES;
        drain();
        // Oversized height clamps to the row limit; the frame is cut off early.
        write_reg(fnac_pkg::REG_MAP_WIDTH, 64'd1);
        write_reg(fnac_pkg::REG_MAP_HEIGHT, 64'd2047);
        for (i = 0; i < TALL_TILES; i++) queue_tile(random_tile(50));
        drain();
      end
      fed = 0;
      while (fed < RANDOM_TILES) begin
        random_layout(RANDOM_TILES - fed, n);
        fed += n;
      end
    end

    repeat (20) @(negedge clk);
    if (mismatch_count == 0 && texel_q.size() == 0)
      $display("Regression PASS");
    else
      $display("Regression FAIL");
    $finish;
  end

endmodule

FILE: four_neighbor_autotile_classifier_unit.f
+incdir+hdl
hdl/fnac_pkg.sv
hdl/fnac_ctrl.sv
hdl/fnac_datapath.sv
hdl/four_neighbor_autotile_classifier_unit.sv
tb/tb.sv
